[sv/lcs_pkg.sv]
`timescale 1ns / 1ps
// lcs_pkg: shared types, request codes, fixed-point helpers and activation tables
// for the lstm cell step core; no dependencies

package lcs_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned UNIT_W   = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ACC_W    = 40;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned TAB_SIZE = 512;
    localparam int unsigned TAB_AW   = 9;

    localparam logic [TYPE_W-1:0] REQ_PARAM = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_X     = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_H     = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_C     = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_RUN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic signed [DATA_W-1:0] Q_ONE = 16'sd4096;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [UNIT_W-1:0]        unit_index;
        logic signed [DATA_W-1:0] hidden_value;
        logic signed [DATA_W-1:0] cell_value;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        A_WEIGHT,
        A_BIAS,
        A_ACT_F,
        A_ACT_I,
        A_ACT_O
    } a_src_t;

    typedef enum logic [2:0] {
        B_X,
        B_H,
        B_C,
        B_ONE,
        B_ACT_G,
        B_TANH_C
    } b_src_t;

    typedef struct packed {
        mac_ctl_t ctl;
        a_src_t   a_src;
        b_src_t   b_src;
    } mac_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATE,
        S_G_WAIT,
        S_CELL,
        S_C_WAIT,
        S_HIDE,
        S_H_WAIT
    } state_t;

    typedef logic signed [DATA_W-1:0] tab_t [TAB_SIZE];

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] q;
        a = acc + ACC_W'(2048);
        q = a >>> 12;
        if (q > ACC_W'(32767))
            return 16'sh7fff;
        else if (q < -ACC_W'(32768))
            return 16'sh8000;
        else
            return q[DATA_W-1:0];
    endfunction

    function automatic logic [TAB_AW-1:0] tab_idx(input logic signed [DATA_W-1:0] v);
        return {~v[DATA_W-1], v[DATA_W-2:7]};
    endfunction

    // shift-subtract quotient, used only while building the constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] e;
        u2 = (u * u) >> 30;
        u3 = (u2 * u) >> 30;
        u4 = (u3 * u) >> 30;
        e = (64'd1 << 30) - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
        for (int n = 0; n < 8; n++)
            e = (e * e + (64'd1 << 29)) >> 30;
        return e;
    endfunction

    function automatic tab_t build_tab(input bit is_tanh);
        tab_t        t;
        int          d;
        logic [63:0] m;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] r;
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            d = 2 * k + 1 - TAB_SIZE;
            m = 64'(d < 0 ? -d : d);
            if (!is_tanh)
            begin
                e = exp_neg_q30(m << 16);
                num = (d >= 0) ? (64'd1 << 30) : e;
                den = (64'd1 << 30) + e;
                r = udiv64(num * 64'd4096 + (den >> 1), den);
                t[k] = r[DATA_W-1:0];
            end
            else
            begin
                e = exp_neg_q30(m << 17);
                den = (64'd1 << 30) + e;
                r = udiv64(((64'd1 << 30) - e) * 64'd4096 + (den >> 1), den);
                t[k] = (d >= 0) ? r[DATA_W-1:0] : -r[DATA_W-1:0];
            end
        end
        return t;
    endfunction

    localparam tab_t SIG_TAB  = build_tab(1'b0);
    localparam tab_t TANH_TAB = build_tab(1'b1);

endpackage

[sv/lcs_mac.sv]
`timescale 1ns / 1ps
// lcs_mac: shared 16x16 multiplier with registered product and wide accumulator
// depends on lcs_pkg

module lcs_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcs_pkg::mac_ctl_t                 ctl,
    input  logic signed [lcs_pkg::DATA_W-1:0] a,
    input  logic signed [lcs_pkg::DATA_W-1:0] b,
    output logic signed [lcs_pkg::ACC_W-1:0]  acc,
    output logic                              busy
);
    import lcs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 pctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (pctl_reg.valid)
        begin
            if (pctl_reg.first)
                acc_next = ACC_W'(prod_reg);
            else
                acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pctl_reg <= '0;
        else
            pctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = pctl_reg.valid;

endmodule

[sv/lstm_cell_step_core.sv]
`timescale 1ns / 1ps
// lstm_cell_step_core: lstm inference cell, stores, sequencer and output register
// depends on lcs_pkg and lcs_mac
// one product per cycle through the single shared multiply-accumulate unit while
// the sequencer issues, pausing in its wait states and while the output is stalled
// results leave one per row
// reset clears the sequencer, counts (to 64) and output valid; stores are undefined

module lstm_cell_step_core #(
    parameter int NUM_IN  = 64,
    parameter int NUM_OUT = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lcs_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lcs_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcs_pkg::COUNT_W-1:0]          cfg_data
);
    import lcs_pkg::*;

    localparam int ROW_LEN = NUM_IN + NUM_OUT;
    localparam int W_DEPTH = 4 * NUM_OUT * ROW_LEN;
    localparam int B_DEPTH = 8 * NUM_OUT;
    localparam int W_AW    = $clog2(W_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);
    localparam int IN_AW   = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
    localparam int OUT_AW  = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;

    logic signed [DATA_W-1:0] w_mem [W_DEPTH];
    logic signed [DATA_W-1:0] b_mem [B_DEPTH];
    logic signed [DATA_W-1:0] x_mem [NUM_IN];
    logic signed [DATA_W-1:0] h_mem [NUM_OUT];
    logic signed [DATA_W-1:0] c_mem [NUM_OUT];

    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;
    logic signed [DATA_W-1:0] x_rd_reg;
    logic signed [DATA_W-1:0] h_rd_reg;
    logic signed [DATA_W-1:0] c_rd_reg;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0] in_count_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] nin;
    logic [COUNT_W-1:0] nout;

    logic [7:0]        cnt_reg;
    logic [7:0]        cnt_next;
    logic [1:0]        gate_reg;
    logic [1:0]        gate_next;
    logic [UNIT_W-1:0] row_reg;
    logic [UNIT_W-1:0] row_next;

    logic signed [DATA_W-1:0] act_reg [4];
    logic signed [DATA_W-1:0] act_next [4];
    logic signed [DATA_W-1:0] c_reg;
    logic signed [DATA_W-1:0] c_next;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    mac_op_t op;
    mac_op_t iss_reg;
    logic [W_AW-1:0]    w_ra;
    logic [B_AW-1:0]    b_ra;
    logic [COUNT_W-1:0] vec_idx;

    logic signed [DATA_W-1:0] mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mac_busy;
    logic                     inflight;
    logic                     out_free;
    logic                     in_xfer;
    logic                     run_go;
    logic                     is_last_op;
    logic [7:0]               xcol;
    logic [7:0]               hcol;
    logic signed [DATA_W-1:0] gate_arg;
    logic signed [DATA_W-1:0] gate_act;
    logic [15:0]              b_wr_addr;

    assign nin  = (in_count_reg > COUNT_W'(NUM_IN)) ? COUNT_W'(NUM_IN) : in_count_reg;
    assign nout = (out_count_reg > COUNT_W'(NUM_OUT)) ? COUNT_W'(NUM_OUT) : out_count_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign run_go    = in_xfer && (in_data.req_type == REQ_RUN) && (nout != '0);
    assign cfg_ready = 1'b1;
    assign inflight  = iss_reg.ctl.valid || mac_busy;
    assign out_free  = !out_valid_reg || !out_stall;
    assign b_wr_addr = in_data.address - 16'(W_DEPTH);

    assign xcol       = cnt_reg - 8'd2;
    assign hcol       = cnt_reg - 8'd2 - 8'(nin);
    assign is_last_op = (cnt_reg == 8'd1 + 8'(nin) + 8'(nout));

    assign gate_arg = round_sat(mac_acc);
    assign gate_act = (gate_reg == 2'd2) ? TANH_TAB[tab_idx(gate_arg)]
                                         : SIG_TAB[tab_idx(gate_arg)];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= COUNT_RESET;
            out_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_INPUT_COUNT)
                in_count_reg <= cfg_data;
            else if (cfg_index == CFG_OUTPUT_COUNT)
                out_count_reg <= cfg_data;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.req_type == REQ_PARAM && 32'(in_data.address) < W_DEPTH)
            w_mem[in_data.address[W_AW-1:0]] <= in_data.value;
        w_rd_reg <= w_mem[w_ra];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.req_type == REQ_PARAM && 32'(in_data.address) >= W_DEPTH
            && 32'(in_data.address) < W_DEPTH + B_DEPTH)
            b_mem[b_wr_addr[B_AW-1:0]] <= in_data.value;
        b_rd_reg <= b_mem[b_ra];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.req_type == REQ_X && 32'(in_data.address) < NUM_IN)
            x_mem[in_data.address[IN_AW-1:0]] <= in_data.value;
        x_rd_reg <= x_mem[vec_idx[IN_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.req_type == REQ_H && 32'(in_data.address) < NUM_OUT)
            h_mem[in_data.address[OUT_AW-1:0]] <= in_data.value;
        h_rd_reg <= h_mem[vec_idx[OUT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.req_type == REQ_C && 32'(in_data.address) < NUM_OUT)
            c_mem[in_data.address[OUT_AW-1:0]] <= in_data.value;
        c_rd_reg <= c_mem[vec_idx[OUT_AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (run_go)
                    state_next = S_GATE;
            S_GATE:
                if (is_last_op)
                    state_next = S_G_WAIT;
            S_G_WAIT:
                if (!inflight)
                    state_next = (gate_reg == 2'd3) ? S_CELL : S_GATE;
            S_CELL:
                if (cnt_reg != 8'd0)
                    state_next = S_C_WAIT;
            S_C_WAIT:
                if (!inflight)
                    state_next = S_HIDE;
            S_HIDE:
                state_next = S_H_WAIT;
            S_H_WAIT:
                if (!inflight && out_free)
                    state_next = (7'(row_reg) + 7'd1 == nout) ? S_IDLE : S_GATE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        gate_next      = gate_reg;
        row_next       = row_reg;
        act_next       = act_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        op             = '{ctl: '0, a_src: A_WEIGHT, b_src: B_X};
        w_ra           = '0;
        b_ra           = '0;
        vec_idx        = '0;
        case (state_reg)
            S_IDLE:
                if (run_go)
                begin
                    cnt_next  = '0;
                    gate_next = '0;
                    row_next  = '0;
                end
            S_GATE:
            begin
                op.ctl.valid = 1'b1;
                op.ctl.first = (cnt_reg == 8'd0);
                cnt_next     = is_last_op ? 8'd0 : cnt_reg + 8'd1;
                if (cnt_reg < 8'd2)
                begin
                    op.a_src = A_BIAS;
                    op.b_src = B_ONE;
                    b_ra = B_AW'((32'(cnt_reg) * 4 + 32'(gate_reg)) * NUM_OUT + 32'(row_reg));
                end
                else if (xcol < 8'(nin))
                begin
                    op.a_src = A_WEIGHT;
                    op.b_src = B_X;
                    vec_idx  = xcol[COUNT_W-1:0];
                    w_ra = W_AW'((32'(gate_reg) * NUM_OUT + 32'(row_reg)) * ROW_LEN
                                 + 32'(xcol));
                end
                else
                begin
                    op.a_src = A_WEIGHT;
                    op.b_src = B_H;
                    vec_idx  = hcol[COUNT_W-1:0];
                    w_ra = W_AW'((32'(gate_reg) * NUM_OUT + 32'(row_reg)) * ROW_LEN
                                 + NUM_IN + 32'(hcol));
                end
            end
            S_G_WAIT:
                if (!inflight)
                begin
                    act_next[gate_reg] = gate_act;
                    gate_next          = gate_reg + 2'd1;
                end
            S_CELL:
            begin
                op.ctl.valid = 1'b1;
                vec_idx      = 7'(row_reg);
                if (cnt_reg == 8'd0)
                begin
                    op.ctl.first = 1'b1;
                    op.a_src     = A_ACT_F;
                    op.b_src     = B_C;
                    cnt_next     = 8'd1;
                end
                else
                begin
                    op.a_src = A_ACT_I;
                    op.b_src = B_ACT_G;
                    cnt_next = 8'd0;
                end
            end
            S_C_WAIT:
                if (!inflight)
                    c_next = gate_arg;
            S_HIDE:
            begin
                op.ctl.valid = 1'b1;
                op.ctl.first = 1'b1;
                op.a_src     = A_ACT_O;
                op.b_src     = B_TANH_C;
            end
            S_H_WAIT:
                if (!inflight && out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.unit_index   = row_reg;
                    out_data_next.hidden_value = gate_arg;
                    out_data_next.cell_value   = c_reg;
                    out_data_next.last         = (7'(row_reg) + 7'd1 == nout);
                    row_next                   = row_reg + 6'd1;
                end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            gate_reg      <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            iss_reg       <= '{ctl: '0, a_src: A_WEIGHT, b_src: B_X};
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gate_reg      <= gate_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            iss_reg       <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        c_reg        <= c_next;
        out_data_reg <= out_data_next;
    end

    // operand select, aligned with the registered reads
    always_comb
    begin
        case (iss_reg.a_src)
            A_WEIGHT: mac_a = w_rd_reg;
            A_BIAS:   mac_a = b_rd_reg;
            A_ACT_F:  mac_a = act_reg[1];
            A_ACT_I:  mac_a = act_reg[0];
            A_ACT_O:  mac_a = act_reg[3];
            default:  mac_a = '0;
        endcase
        case (iss_reg.b_src)
            B_X:      mac_b = x_rd_reg;
            B_H:      mac_b = h_rd_reg;
            B_C:      mac_b = c_rd_reg;
            B_ONE:    mac_b = Q_ONE;
            B_ACT_G:  mac_b = act_reg[2];
            B_TANH_C: mac_b = TANH_TAB[tab_idx(c_reg)];
            default:  mac_b = '0;
        endcase
    end

    lcs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (iss_reg.ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_last_is_final_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last) |-> (7'(out_data.unit_index) + 7'd1 == nout))
        else $error("last flag on a unit other than the final one");

    a_issue_reaches_mac: assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg.ctl.valid |=> mac_busy)
        else $error("issued operation did not reach the multiplier");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (7'(row_reg) < nout))
        else $error("row counter beyond unit count during a run");

endmodule
